>>> rtl/tspmm_pkg.sv
// ============================================================================
// tspmm_pkg: shared types and constants of the exhaustive tour search
// Transaction payloads, register indexes, request and tour codes, sum limits.
// ============================================================================
package tspmm_pkg;

    // default sizing handed to the top level
    localparam int MAX_CITIES_DEF  = 8;
    localparam int WEIGHT_BITS_DEF = 8;

    // fixed field widths
    localparam int CITY_W     = 4;
    localparam int FROM_W     = 3;
    localparam int EDGE_W     = 8;
    localparam int SUM_W      = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    // saturation limit of a tour sum
    localparam logic [SUM_W-1:0] SUM_MAX = 11'd2047;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CITY_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOME_CITY  = 1'd1;

    // configuration reset values
    localparam logic [CITY_W-1:0] CITY_COUNT_RST = 4'd8;
    localparam logic [CITY_W-1:0] HOME_CITY_RST  = 4'd1;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_RUN   = 1'b1;

    // tour kind codes
    localparam logic KIND_BEST  = 1'b0;
    localparam logic KIND_WORST = 1'b1;

    // input transaction
    typedef struct packed {
        logic              req_type;
        logic [FROM_W-1:0] from_city;
        logic [FROM_W-1:0] to_city;
        logic [EDGE_W-1:0] edge_weight;
    } t_req;

    // output transaction
    typedef struct packed {
        logic              tour_kind;
        logic [CITY_W-1:0] position;
        logic [CITY_W-1:0] city;
        logic [SUM_W-1:0]  tour_weight;
        logic              last;
    } t_result;

endpackage

>>> rtl/tspmm_wmem.sv
// ============================================================================
// tspmm_wmem: weight matrix memory
// One write port, one read port with registered read data, row by column.
// ============================================================================
module tspmm_wmem
    import tspmm_pkg::*;
#(
    parameter int MAX_CITIES  = MAX_CITIES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    parameter int IDX_W       = $clog2(MAX_CITIES)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [2*IDX_W-1:0]     i_waddr,
    input  logic [WEIGHT_BITS-1:0] i_wdata,
    input  logic [2*IDX_W-1:0]     i_raddr,
    output logic [WEIGHT_BITS-1:0] o_rdata
);

    localparam int DEPTH = 1 << (2 * IDX_W);

    logic [WEIGHT_BITS-1:0] mem [0:DEPTH-1];
    logic [WEIGHT_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tspmm_ordrf.sv
// ============================================================================
// tspmm_ordrf: register file of the current city ordering
// One write and one read address per cycle; permutation steps go through it.
// ============================================================================
module tspmm_ordrf
    import tspmm_pkg::*;
#(
    parameter int DEPTH = MAX_CITIES_DEF + 1,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [CITY_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [CITY_W-1:0] o_rdata
);

    logic [CITY_W-1:0] r_ord [0:DEPTH-1];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ord[i_waddr] <= i_wdata;
        end
    end

    // read port
    assign o_rdata = r_ord[i_raddr];

endmodule

>>> rtl/tsp_exhaustive_min_max_tour_top.sv
// ============================================================================
// A run visits all (n-1)! tours of n cities: each tour is summed through the single
// saturating adder, compared once, and advanced by a permutation step through the
// read and write ports of the order register file; then 2(n+1) result transactions
// follow, one per cycle while i_out_ready does not stall the output.
// Synchronous active-low reset clears control state and sets the city count to 8,
// the home city to 1; the weight matrix is undefined until written.
// ============================================================================
// tsp_exhaustive_min_max_tour_top: brute-force tour search, cheapest and dearest
// Sequencer over a shared adder, compare unit, order file and weight memory.
// ============================================================================
module tsp_exhaustive_min_max_tour_top
    import tspmm_pkg::*;
#(
    parameter int MAX_CITIES  = MAX_CITIES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_req                  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_result               o_out_data
);

    localparam int IDX_W = $clog2(MAX_CITIES);
    localparam int POS_W = $clog2(MAX_CITIES + 1);
    localparam int CNT_W = $clog2(MAX_CITIES + 3);
    localparam int ADD_W = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_INIT     = 12'b0000_0000_0010,
        S_SUM      = 12'b0000_0000_0100,
        S_CMP      = 12'b0000_0000_1000,
        S_ADV_LOAD = 12'b0000_0001_0000,
        S_SCAN_I   = 12'b0000_0010_0000,
        S_SCAN_J   = 12'b0000_0100_0000,
        S_SWAP     = 12'b0000_1000_0000,
        S_REV_RD   = 12'b0001_0000_0000,
        S_REV_W1   = 12'b0010_0000_0000,
        S_REV_W2   = 12'b0100_0000_0000,
        S_OUT      = 12'b1000_0000_0000
    } t_state;

    // control registers
    t_state            r_state, n_state;
    logic [CITY_W-1:0] r_city_count, r_home_city;
    logic              r_v1, n_v1, r_v2, n_v2;
    logic              r_out_valid, n_out_valid;

    // datapath registers
    logic [CITY_W-1:0] r_n, n_n, r_s, n_s, r_c, n_c;
    logic [CNT_W-1:0]  r_p, n_p;
    logic [POS_W-1:0]  r_i, n_i, r_j, n_j, r_lo, n_lo, r_hi, n_hi;
    logic [CITY_W-1:0] r_nxt, n_nxt, r_piv, n_piv, r_tmp, n_tmp;
    logic [CITY_W-1:0] r_cur, n_cur, r_prev, n_prev;
    logic              r_pair, n_pair, r_first, n_first, r_kind, n_kind;
    logic [SUM_W-1:0]  r_sum, n_sum, r_best_w, n_best_w, r_worst_w, n_worst_w;
    logic [CITY_W-1:0] r_cand  [0:MAX_CITIES];
    logic [CITY_W-1:0] r_best  [0:MAX_CITIES];
    logic [CITY_W-1:0] r_worst [0:MAX_CITIES];
    t_result           r_out_data, n_out_data;

    // combinational helpers
    logic                   in_acc;
    logic [CITY_W-1:0]      run_n, run_s, init_city;
    logic [POS_W-1:0]       hi_idx, pos_idx;
    logic                   ord_we;
    logic [POS_W-1:0]       ord_waddr, ord_raddr;
    logic [CITY_W-1:0]      ord_wdata, ord_rdata;
    logic                   wm_we;
    logic [2*IDX_W-1:0]     wm_waddr, wm_raddr;
    logic [WEIGHT_BITS-1:0] wm_wdata, wm_rdata;
    logic [CITY_W-1:0]      city_a, city_b;
    logic [ADD_W-1:0]       add_raw;
    logic [SUM_W-1:0]       sat_sum;
    logic                   cand_we, best_ld, worst_ld, out_load;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign pos_idx    = r_p[POS_W-1:0];
    assign hi_idx     = POS_W'(r_n - CITY_W'(1));

    // clamp of the configured city count and start city
    always_comb begin
        if (r_city_count < CITY_W'(2)) begin
            run_n = CITY_W'(2);
        end else if (r_city_count > CITY_W'(MAX_CITIES)) begin
            run_n = CITY_W'(MAX_CITIES);
        end else begin
            run_n = r_city_count;
        end
        if (r_home_city == '0 || r_home_city > run_n) begin
            run_s = CITY_W'(1);
        end else begin
            run_s = r_home_city;
        end
    end

    // next city of the ascending start ordering, skipping the start city
    assign init_city = (r_c == r_s) ? r_c + CITY_W'(1) : r_c;

    // matrix write from a weight transaction
    assign wm_we    = in_acc && (i_in_data.req_type == REQ_WRITE)
                      && (int'(i_in_data.from_city) < MAX_CITIES)
                      && (int'(i_in_data.to_city) < MAX_CITIES);
    assign wm_waddr = {IDX_W'(i_in_data.from_city), IDX_W'(i_in_data.to_city)};
    assign wm_wdata = WEIGHT_BITS'(i_in_data.edge_weight);

    // matrix read for the edge between the two latest cities
    assign city_a   = r_prev - CITY_W'(1);
    assign city_b   = r_cur - CITY_W'(1);
    assign wm_raddr = {IDX_W'(city_a), IDX_W'(city_b)};

    // shared saturating adder
    assign add_raw = ADD_W'(r_sum) + ADD_W'(wm_rdata);
    assign sat_sum = (add_raw > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(add_raw);

    tspmm_wmem #(
        .MAX_CITIES  (MAX_CITIES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_W       (IDX_W)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_we    (wm_we),
        .i_waddr (wm_waddr),
        .i_wdata (wm_wdata),
        .i_raddr (wm_raddr),
        .o_rdata (wm_rdata)
    );

    tspmm_ordrf #(
        .DEPTH (MAX_CITIES + 1),
        .IDX_W (POS_W)
    ) u_ordrf (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_s       = r_s;
        n_c       = r_c;
        n_p       = r_p;
        n_i       = r_i;
        n_j       = r_j;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_nxt     = r_nxt;
        n_piv     = r_piv;
        n_tmp     = r_tmp;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_pair    = r_pair;
        n_first   = r_first;
        n_kind    = r_kind;
        n_sum     = r_sum;
        n_best_w  = r_best_w;
        n_worst_w = r_worst_w;
        n_v1      = 1'b0;
        n_v2      = 1'b0;
        ord_we    = 1'b0;
        ord_waddr = pos_idx;
        ord_wdata = r_s;
        ord_raddr = pos_idx;
        cand_we   = 1'b0;
        best_ld   = 1'b0;
        worst_ld  = 1'b0;
        out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.req_type == REQ_RUN) begin
                    n_n     = run_n;
                    n_s     = run_s;
                    n_p     = '0;
                    n_c     = CITY_W'(1);
                    n_state = S_INIT;
                end
            end
            // write the start ordering, one position a cycle
            S_INIT: begin
                ord_we = 1'b1;
                if (r_p != '0 && r_p != CNT_W'(r_n)) begin
                    ord_wdata = init_city;
                    n_c       = init_city + CITY_W'(1);
                end
                if (r_p == CNT_W'(r_n)) begin
                    n_p     = '0;
                    n_sum   = '0;
                    n_first = 1'b1;
                    n_state = S_SUM;
                end else begin
                    n_p = r_p + CNT_W'(1);
                end
            end
            // order read, matrix read, accumulate: three-deep pipeline
            S_SUM: begin
                if (r_p <= CNT_W'(r_n)) begin
                    n_cur   = ord_rdata;
                    n_prev  = r_cur;
                    cand_we = 1'b1;
                    n_v1    = 1'b1;
                    n_pair  = (r_p != '0);
                end
                n_v2 = r_v1 && r_pair;
                if (r_v2) begin
                    n_sum = sat_sum;
                end
                if (r_p == CNT_W'(r_n) + CNT_W'(2)) begin
                    n_state = S_CMP;
                end else begin
                    n_p = r_p + CNT_W'(1);
                end
            end
            // keep the first strictly cheaper and strictly dearer tour
            S_CMP: begin
                if (r_first || r_sum < r_best_w) begin
                    n_best_w = r_sum;
                    best_ld  = 1'b1;
                end
                if (r_first || r_sum > r_worst_w) begin
                    n_worst_w = r_sum;
                    worst_ld  = 1'b1;
                end
                n_first = 1'b0;
                n_state = S_ADV_LOAD;
            end
            // next permutation: fetch the tail entry; with fewer than three cities, go to output
            S_ADV_LOAD: begin
                ord_raddr = hi_idx;
                if (r_n < CITY_W'(3)) begin
                    n_p     = '0;
                    n_kind  = KIND_BEST;
                    n_state = S_OUT;
                end else begin
                    n_nxt   = ord_rdata;
                    n_i     = hi_idx - POS_W'(1);
                    n_state = S_SCAN_I;
                end
            end
            // scan down for the pivot
            S_SCAN_I: begin
                ord_raddr = r_i;
                if (ord_rdata >= r_nxt) begin
                    if (r_i == POS_W'(1)) begin
                        n_p     = '0;
                        n_kind  = KIND_BEST;
                        n_state = S_OUT;
                    end else begin
                        n_nxt = ord_rdata;
                        n_i   = r_i - POS_W'(1);
                    end
                end else begin
                    n_piv   = ord_rdata;
                    n_j     = hi_idx;
                    n_state = S_SCAN_J;
                end
            end
            // scan down for the successor, write the pivot in its place
            S_SCAN_J: begin
                ord_raddr = r_j;
                if (r_piv >= ord_rdata) begin
                    n_j = r_j - POS_W'(1);
                end else begin
                    ord_we    = 1'b1;
                    ord_waddr = r_j;
                    ord_wdata = r_piv;
                    n_tmp     = ord_rdata;
                    n_state   = S_SWAP;
                end
            end
            S_SWAP: begin
                ord_we    = 1'b1;
                ord_waddr = r_i;
                ord_wdata = r_tmp;
                n_lo      = r_i + POS_W'(1);
                n_hi      = hi_idx;
                n_state   = S_REV_RD;
            end
            // reverse the suffix, each swap by a read state and then two write states
            S_REV_RD: begin
                ord_raddr = r_lo;
                if (r_lo >= r_hi) begin
                    n_p     = '0;
                    n_sum   = '0;
                    n_state = S_SUM;
                end else begin
                    n_tmp   = ord_rdata;
                    n_state = S_REV_W1;
                end
            end
            S_REV_W1: begin
                ord_raddr = r_hi;
                ord_we    = 1'b1;
                ord_waddr = r_lo;
                ord_wdata = ord_rdata;
                n_state   = S_REV_W2;
            end
            S_REV_W2: begin
                ord_we    = 1'b1;
                ord_waddr = r_hi;
                ord_wdata = r_tmp;
                n_lo      = r_lo + POS_W'(1);
                n_hi      = r_hi - POS_W'(1);
                n_state   = S_REV_RD;
            end
            // emit the cheapest tour, then the dearest
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    if (r_p == CNT_W'(r_n)) begin
                        if (r_kind == KIND_WORST) begin
                            n_state = S_IDLE;
                        end else begin
                            n_kind = KIND_WORST;
                            n_p    = '0;
                        end
                    end else begin
                        n_p = r_p + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register contents
    always_comb begin
        n_out_data = r_out_data;
        if (out_load) begin
            n_out_data.tour_kind = r_kind;
            n_out_data.position  = CITY_W'(r_p);
            if (r_kind == KIND_WORST) begin
                n_out_data.city        = r_worst[pos_idx];
                n_out_data.tour_weight = r_worst_w;
            end else begin
                n_out_data.city        = r_best[pos_idx];
                n_out_data.tour_weight = r_best_w;
            end
            n_out_data.last = (r_kind == KIND_WORST) && (r_p == CNT_W'(r_n));
        end
        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_city_count <= CITY_COUNT_RST;
            r_home_city  <= HOME_CITY_RST;
        end else begin
            r_state     <= n_state;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_CITY_COUNT: r_city_count <= CITY_W'(i_cfg_wdata);
                    REG_HOME_CITY:  r_home_city  <= CITY_W'(i_cfg_wdata);
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_s        <= n_s;
        r_c        <= n_c;
        r_p        <= n_p;
        r_i        <= n_i;
        r_j        <= n_j;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_nxt      <= n_nxt;
        r_piv      <= n_piv;
        r_tmp      <= n_tmp;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_pair     <= n_pair;
        r_first    <= n_first;
        r_kind     <= n_kind;
        r_sum      <= n_sum;
        r_best_w   <= n_best_w;
        r_worst_w  <= n_worst_w;
        r_out_data <= n_out_data;
        if (cand_we) begin
            r_cand[pos_idx] <= ord_rdata;
        end
        if (best_ld) begin
            r_best <= r_cand;
        end
        if (worst_ld) begin
            r_worst <= r_cand;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
